[hdl/rspe_pkg.sv]
package rspe_pkg;

  localparam int unsigned DEF_PARITY_SYMBOLS = 32;
  localparam int unsigned MAX_PARITY_SYMBOLS = 64;
  localparam logic [8:0]  FIELD_POLY         = 9'h11D;
  localparam int unsigned FIELD_ORDER        = 255;
  localparam logic [7:0]  DEF_MSG_LEN        = 8'd223;

  // Register indexes on the configuration port
  localparam logic REG_MSG_LEN = 1'b0;

  typedef logic [7:0] sym_t;

  function automatic sym_t gf_mul(sym_t x, sym_t y);
    logic [8:0] a;
    sym_t       b;
    sym_t       r;
    a = {1'b0, x};
    b = y;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) begin
        r = r ^ a[7:0];
      end
      a = {a[7:0], 1'b0};
      if (a[8]) begin
        a = a ^ FIELD_POLY;
      end
      b = b >> 1;
    end
    return r;
  endfunction

  // Coefficient idx of prod (x + alpha^i), i = 1..p, alpha = 2
  function automatic sym_t gen_coef(int p, int idx);
    sym_t g [0:MAX_PARITY_SYMBOLS];
    sym_t root;
    for (int k = 0; k <= MAX_PARITY_SYMBOLS; k++) begin
      g[k] = '0;
    end
    g[0] = 8'd1;
    root = 8'd2;
    for (int i = 0; i < p; i++) begin
      for (int j = i + 1; j > 0; j--) begin
        g[j] = g[j-1] ^ gf_mul(g[j], root);
      end
      g[0] = gf_mul(g[0], root);
      root = gf_mul(root, 8'd2);
    end
    return g[idx];
  endfunction

endpackage

[hdl/rspe_if.sv]
interface rspe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;

  modport source (output valid, output message_byte, input ready);
  modport sink   (input valid, input message_byte, output ready);
endinterface

interface rspe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       is_parity;
  logic       end_of_codeword;

  modport source (output valid, output code_byte, output is_parity, output end_of_codeword,
                  input ready);
  modport sink   (input valid, input code_byte, input is_parity, input end_of_codeword,
                  output ready);
endinterface

[hdl/rspe_cell.sv]
module rspe_cell
  import rspe_pkg::*;
#(
  parameter sym_t COEF = 8'd1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  sym_t prev_sym,
  input  sym_t feedback,
  output sym_t cell_sym
);

  sym_t cell_r;
  sym_t cell_nxt;

  // Constant multiplier: synthesis folds gf_mul into a small XOR network
  always_comb begin
    cell_nxt = cell_r;
    if (advance) begin
      cell_nxt = prev_sym ^ gf_mul(COEF, feedback);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_sym = cell_r;

endmodule

[hdl/rspe_cfg.sv]
module rspe_cfg
  import rspe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output sym_t        message_length
);

  sym_t msg_len_r;
  sym_t msg_len_nxt;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    msg_len_nxt = msg_len_r;
    if (wr_en && cfg_paddr[2] == REG_MSG_LEN) begin
      msg_len_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r <= DEF_MSG_LEN;
    end else begin
      msg_len_r <= msg_len_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_MSG_LEN) begin
      cfg_prdata = {24'd0, msg_len_r};
    end
  end

  assign message_length = msg_len_r;

endmodule

[hdl/reed_solomon_parity_encoder.sv]
// A message byte appears at the output, registered, in the cycle after its transfer.
// Throughput: one message byte per cycle unless the output stalls; after the last byte
// of a codeword the PARITY_SYMBOLS parity bytes shift out of the cell chain, one per
// cycle unless the output stalls, and input is held off until they are all out.
// Reset (rst_n, synchronous): cells and count cleared, message length 223.
module reed_solomon_parity_encoder
  import rspe_pkg::*;
#(
  parameter int unsigned PARITY_SYMBOLS = DEF_PARITY_SYMBOLS
) (
  input  logic        clk,
  input  logic        rst_n,
  rspe_in_if.sink     in_ch,
  rspe_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned CNT_W   = $clog2(PARITY_SYMBOLS + 1);
  localparam logic [8:0]  MAX_LEN = 9'(FIELD_ORDER - PARITY_SYMBOLS);

  sym_t message_length;
  sym_t cell_q [PARITY_SYMBOLS];
  sym_t top_sym;
  sym_t feedback;
  logic advance;
  logic in_fire;
  logic out_free;
  logic drain_step;
  logic is_last;
  logic [8:0] eff_len;

  logic             out_valid_r, out_valid_nxt;
  sym_t             code_r, code_nxt;
  logic             par_r, par_nxt;
  logic             eoc_r, eoc_nxt;
  sym_t             seen_r, seen_nxt;
  logic             drain_r, drain_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  rspe_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .message_length (message_length)
  );

  assign top_sym    = cell_q[PARITY_SYMBOLS-1];
  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !drain_r && out_free;
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign drain_step = drain_r && out_free;
  assign advance    = in_fire || drain_step;
  // Zero feedback while draining turns the chain into a plain shift register
  assign feedback   = drain_r ? 8'd0 : (in_ch.message_byte ^ top_sym);

  for (genvar j = 0; j < PARITY_SYMBOLS; j++) begin : g_cell
    rspe_cell #(
      .COEF (gen_coef(PARITY_SYMBOLS, j))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .prev_sym ((j == 0) ? 8'd0 : cell_q[(j == 0) ? 0 : j-1]),
      .feedback (feedback),
      .cell_sym (cell_q[j])
    );
  end

  // Clamp the programmed length into 1 .. 255 - PARITY_SYMBOLS
  always_comb begin
    eff_len = {1'b0, message_length};
    if (eff_len == 9'd0) begin
      eff_len = 9'd1;
    end
    if (eff_len > MAX_LEN) begin
      eff_len = MAX_LEN;
    end
  end

  assign is_last = ({1'b0, seen_r} + 9'd1) >= eff_len;

  always_comb begin
    out_valid_nxt = out_valid_r;
    code_nxt      = code_r;
    par_nxt       = par_r;
    eoc_nxt       = eoc_r;
    seen_nxt      = seen_r;
    drain_nxt     = drain_r;
    cnt_nxt       = cnt_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      code_nxt      = in_ch.message_byte;
      par_nxt       = 1'b0;
      eoc_nxt       = 1'b0;
      if (is_last) begin
        seen_nxt  = '0;
        drain_nxt = 1'b1;
        cnt_nxt   = CNT_W'(PARITY_SYMBOLS);
      end else begin
        seen_nxt = seen_r + 8'd1;
      end
    end else if (drain_step) begin
      out_valid_nxt = 1'b1;
      code_nxt      = top_sym;
      par_nxt       = 1'b1;
      eoc_nxt       = (cnt_r == CNT_W'(1));
      cnt_nxt       = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        drain_nxt = 1'b0;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      seen_r      <= '0;
      drain_r     <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      seen_r      <= seen_nxt;
      drain_r     <= drain_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    par_r  <= par_nxt;
    eoc_r  <= eoc_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.code_byte       = code_r;
  assign out_ch.is_parity       = par_r;
  assign out_ch.end_of_codeword = eoc_r;

endmodule

[tb/rspe_codeword_checker.sv]
module rspe_codeword_checker
  import rspe_pkg::*;
#(
  parameter int unsigned NPAR = DEF_PARITY_SYMBOLS
) (
  input  logic        clk,
  input  logic        rst_n,
  rspe_in_if          in_ch,
  rspe_out_if         out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          outstanding,
  output int          codewords,
  output int          msg_bytes
);

  typedef struct packed {
    sym_t code_byte;
    logic is_parity;
    logic end_of_codeword;
  } code_sym_t;

  code_sym_t  expected_code[$];
  sym_t       gen_poly [0:NPAR];
  sym_t       rem_cells [0:NPAR-1];
  logic [7:0] seen_cnt;
  logic [7:0] len_reg;

  // Shift-and-reduce product in GF(2^8)
  function automatic sym_t gf_times(sym_t a, sym_t b);
    sym_t acc;
    sym_t p;
    acc = '0;
    p   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ p;
      end
      p = p[7] ? ((p << 1) ^ FIELD_POLY[7:0]) : (p << 1);
    end
    return acc;
  endfunction

  function automatic int unsigned eff_len(logic [7:0] v);
    if (v == 8'd0) begin
      return 1;
    end
    if (int'(v) > int'(FIELD_ORDER - NPAR)) begin
      return FIELD_ORDER - NPAR;
    end
    return v;
  endfunction

  // g(x) = (x + a^1)(x + a^2)...(x + a^NPAR)
  initial begin
    sym_t root;
    root = 8'd2;
    for (int k = 0; k <= NPAR; k++) begin
      gen_poly[k] = '0;
    end
    gen_poly[0] = 8'd1;
    for (int i = 1; i <= NPAR; i++) begin
      for (int j = i; j > 0; j--) begin
        gen_poly[j] = gen_poly[j-1] ^ gf_times(gen_poly[j], root);
      end
      gen_poly[0] = gf_times(gen_poly[0], root);
      root = gf_times(root, 8'd2);
    end
  end

  task automatic encode_symbol(sym_t b);
    sym_t fb;
    fb = b ^ rem_cells[NPAR-1];
    for (int j = NPAR - 1; j > 0; j--) begin
      rem_cells[j] = rem_cells[j-1] ^ gf_times(gen_poly[j], fb);
    end
    rem_cells[0] = gf_times(gen_poly[0], fb);
    expected_code.push_back('{b, 1'b0, 1'b0});
    if (int'(seen_cnt) + 1 >= int'(eff_len(len_reg))) begin
      // emit parity highest degree first, then clear for the next codeword
      for (int j = 0; j < NPAR; j++) begin
        expected_code.push_back('{rem_cells[NPAR-1-j], 1'b1, (j == NPAR - 1)});
      end
      for (int j = 0; j < NPAR; j++) begin
        rem_cells[j] = '0;
      end
      seen_cnt = '0;
    end else begin
      seen_cnt = seen_cnt + 8'd1;
    end
  endtask

  always @(posedge clk) begin
    code_sym_t want;
    if (!rst_n) begin
      expected_code.delete();
      for (int j = 0; j < NPAR; j++) begin
        rem_cells[j] = '0;
      end
      seen_cnt = '0;
      len_reg  = DEF_MSG_LEN;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == REG_MSG_LEN && cfg_paddr[1:0] == 2'b00) begin
        len_reg = cfg_pwdata[7:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        encode_symbol(in_ch.message_byte);
        msg_bytes++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_code.size() == 0) begin
          $error("unexpected transfer: code_byte %02h is_parity %0b end_of_codeword %0b",
                 out_ch.code_byte, out_ch.is_parity, out_ch.end_of_codeword);
          mismatches++;
        end else begin
          want = expected_code.pop_front();
          if (out_ch.code_byte !== want.code_byte) begin
            $error("code_byte: expected %02h, got %02h", want.code_byte, out_ch.code_byte);
            mismatches++;
          end
          if (out_ch.is_parity !== want.is_parity) begin
            $error("is_parity: expected %0b, got %0b", want.is_parity, out_ch.is_parity);
            mismatches++;
          end
          if (out_ch.end_of_codeword !== want.end_of_codeword) begin
            $error("end_of_codeword: expected %0b, got %0b",
                   want.end_of_codeword, out_ch.end_of_codeword);
            mismatches++;
          end
          if (want.end_of_codeword) begin
            codewords++;
          end
        end
      end
    end
    outstanding = expected_code.size();
  end

endmodule

[tb/tb_reed_solomon_parity_encoder.sv]
module tb_reed_solomon_parity_encoder;
  import rspe_pkg::*;

  localparam int          CYCLE_LIMIT     = 300000;
  localparam int          LONG_HOLD       = 150;
  localparam logic [2:0]  MSG_LEN_ADDR    = {REG_MSG_LEN, 2'b00};
  localparam logic [2:0]  UNUSED_REG_ADDR = 3'd4;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_cnt;
  int pending;
  int codewords;
  int msg_bytes;
  int send_idle_pct;
  int stall_pct;
  int hold_requests;
  int cycles;

  rspe_in_if  in_ch ();
  rspe_out_if out_ch ();

  reed_solomon_parity_encoder i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  rspe_codeword_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (fail_cnt),
    .outstanding (pending),
    .codewords   (codewords),
    .msg_bytes   (msg_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** reed_solomon_parity_encoder: FAILED **");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int holds_done;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < hold_requests) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic sym_t pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return sym_t'($urandom_range(0, 255));
    endcase
  endfunction

  // All tasks start and end at a falling edge
  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic send_byte(sym_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.message_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(logic [7:0] len, int idle, int stall, int n, bit long_hold);
    cfg_write(MSG_LEN_ADDR, {24'd0, len});
    send_idle_pct = idle;
    stall_pct     = stall;
    if (long_hold) begin
      hold_requests++;
    end
    repeat (n) send_byte(pick_byte());
    drain();
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    in_ch.valid        = 1'b0;
    in_ch.message_byte = '0;
    send_idle_pct      = 0;
    stall_pct          = 0;
    hold_requests      = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset length: bytes pass through, no parity yet
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h55);
    send_byte(8'hAA);
    drain();
    // shorten below the count already taken: next byte closes the codeword
    cfg_write(MSG_LEN_ADDR, 32'd3);
    send_byte(8'h7E);
    drain();
    // zero length behaves as one
    cfg_write(MSG_LEN_ADDR, 32'd0);
    send_byte(8'hFF);
    send_byte(8'h00);
    drain();
    // write to a register that does not exist must leave the length alone
    cfg_write(UNUSED_REG_ADDR, 32'd5);
    send_byte(8'h12);
    drain();
    cfg_write(MSG_LEN_ADDR, 32'd2);
    send_byte(8'hC3);
    send_byte(8'h3C);
    drain();

    run_phase(8'($urandom_range(1, 16)), 0, 0, 40, 1'b1);
    run_phase(8'($urandom_range(1, 16)), 77, 0, 35, 1'b0);
    run_phase(8'($urandom_range(1, 16)), 0, 77, 35, 1'b0);
    run_phase(8'($urandom_range(1, 16)), 23, 23, 35, 1'b0);
    run_phase(8'd1, 23, 23, 20, 1'b0);
    // oversized length: bytes keep passing through, the next phase cuts it short
    run_phase(8'd255, 23, 23, 20, 1'b0);
    run_phase(8'($urandom_range(1, 8)), 0, 0, 25, 1'b1);

    repeat (40) @(posedge clk);
    $display("Run covered %0d message bytes in %0d codewords", msg_bytes, codewords);
    $display("Lengths 0, 1, 2, 3, random short and oversized; mid-codeword shortening;");
    $display("write to an unused register; stall, idle and long hold-off phases.");
    if (fail_cnt == 0 && pending == 0) begin
      $display("** reed_solomon_parity_encoder: PASSED **");
    end else begin
      $display("** reed_solomon_parity_encoder: FAILED **");
    end
    $finish;
  end

endmodule
